FILE: design/tad_pkg.sv
// ----------------------------------------------------------------------------
// tad_pkg: shared types and constants of the tone arrival delay block
// Field widths, register and detector codes, the lane control and result bundles,
// the tone table generator used at elaboration and the offset removal function.
// ----------------------------------------------------------------------------
package tad_pkg;

   // field widths
   localparam int SAMPLE_BITS = 16;
   localparam int PROD_W      = SAMPLE_BITS + 1;
   localparam int ROM_FRAC    = 15;
   localparam int POWER_W     = 52;
   localparam int LAG_W       = 16;
   localparam int WINDOW_W    = 11;
   localparam int OFFSET_W    = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 52;
   localparam int NUM_LANES   = 4;

   // default structure
   localparam int TONE_PERIOD_DEF = 24;
   localparam int WINDOW_MAX_DEF  = 1024;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LENGTH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DETECT_LEVEL  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_LEVEL = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEFT_OFFSET   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RIGHT_OFFSET  = 3'd4;

   // register reset values
   localparam logic [WINDOW_W-1:0] WINDOW_RESET  = 11'd480;
   localparam logic [POWER_W-1:0]  DETECT_RESET  = 52'd5000000000;
   localparam logic [POWER_W-1:0]  RELEASE_RESET = 52'd4000000000;

   // detector phases
   localparam logic [1:0] MODE_IDLE         = 2'd0;
   localparam logic [1:0] MODE_WAIT_LEFT    = 2'd1;
   localparam logic [1:0] MODE_WAIT_RIGHT   = 2'd2;
   localparam logic [1:0] MODE_WAIT_RELEASE = 2'd3;

   // lane order
   localparam int LANE_LEFT_SIN  = 0;
   localparam int LANE_LEFT_COS  = 1;
   localparam int LANE_RIGHT_SIN = 2;
   localparam int LANE_RIGHT_COS = 3;

   localparam logic [POWER_W-1:0] POWER_MAX = {POWER_W{1'b1}};
   localparam logic [LAG_W-1:0]   LAG_MAX   = {LAG_W{1'b1}};

   localparam logic [63:0] Q30_ONE     = 64'h0000_0000_4000_0000;
   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

   // per-lane strobes from the sequencing logic
   typedef struct packed {
      logic accept;
      logic load_sum;
      logic load_sq;
      logic warm;
   } lane_ctl_type;

   // one result transfer
   typedef struct packed {
      logic [POWER_W-1:0] left_power;
      logic [POWER_W-1:0] right_power;
      logic               ping_done;
      logic [LAG_W-1:0]   left_lag;
      logic [LAG_W-1:0]   right_lag;
      logic [POWER_W-1:0] left_peak_out;
      logic [POWER_W-1:0] right_peak_out;
      logic [1:0]         detector_phase;
   } result_type;

   // q15 sine of the angle ph / 2^32 of a full turn, q30 polynomial
   function automatic logic signed [SAMPLE_BITS-1:0] tad_rom_value(input logic [31:0] ph);
      logic [1:0]  quad;
      logic [63:0] x;
      logic [63:0] a;
      logic [63:0] a2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] q;
      quad = ph[31:30];
      x    = {34'd0, ph[29:0]};
      if (quad[0]) begin
         x = Q30_ONE - x;
      end
      a  = (x * PI_HALF_Q30) >> 30;
      a2 = (a * a) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((a2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((a2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((a2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((a2 * t) >> 30) / 64'd6;
      s  = (a * t) >> 30;
      q  = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
      if (q > 64'd32767) begin
         q = 64'd32767;
      end
      return quad[1] ? -$signed(q[SAMPLE_BITS-1:0]) : $signed(q[SAMPLE_BITS-1:0]);
   endfunction

   // offset removal, saturated to the sample width
   function automatic logic signed [SAMPLE_BITS-1:0] tad_prep(
      input logic signed [SAMPLE_BITS-1:0] sample,
      input logic signed [OFFSET_W-1:0]    offset);
      logic signed [SAMPLE_BITS:0] diff;
      diff = (SAMPLE_BITS+1)'(sample) - (SAMPLE_BITS+1)'(offset);
      if (diff[SAMPLE_BITS] != diff[SAMPLE_BITS-1]) begin
         return diff[SAMPLE_BITS] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                  : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
      return diff[SAMPLE_BITS-1:0];
   endfunction

endpackage

FILE: design/tad_if.sv
// ----------------------------------------------------------------------------
// tad_if: channel interfaces of the tone arrival delay block
// Sample pair input, result output and register write channels.
// ----------------------------------------------------------------------------

// stereo sample pair channel
interface tad_req_if import tad_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_sample;
   logic signed [SAMPLE_BITS-1:0] right_sample;

   modport source (output valid, left_sample, right_sample, input ready);
   modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

// result channel
interface tad_rsp_if import tad_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [POWER_W-1:0] left_power;
   logic [POWER_W-1:0] right_power;
   logic               ping_done;
   logic [LAG_W-1:0]   left_lag;
   logic [LAG_W-1:0]   right_lag;
   logic [POWER_W-1:0] left_peak_out;
   logic [POWER_W-1:0] right_peak_out;
   logic [1:0]         detector_phase;

   modport source (output valid, left_power, right_power, ping_done, left_lag, right_lag,
                   left_peak_out, right_peak_out, detector_phase, input ready);
   modport sink   (input valid, left_power, right_power, ping_done, left_lag, right_lag,
                   left_peak_out, right_peak_out, detector_phase, output ready);
endinterface

// register write channel
interface tad_csr_if import tad_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/tad_lane.sv
// ----------------------------------------------------------------------------
// tad_lane: one sliding correlator lane
// Mixes a sample with a tone value, keeps the window history in a memory,
// maintains the running sum and squares it.
// ----------------------------------------------------------------------------
module tad_lane import tad_pkg::*; #(
   parameter int  WINDOW_MAX = WINDOW_MAX_DEF,
   localparam int AW         = $clog2(WINDOW_MAX),
   localparam int SUM_W      = PROD_W + AW,
   localparam int SQ_W       = 2 * SUM_W - 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lane_ctl_type                  ctl,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic signed [SAMPLE_BITS-1:0] coef,
   input  logic [AW-1:0]                 rd_addr,
   input  logic [AW-1:0]                 wr_addr,
   output logic [SQ_W-1:0]               square
);

   localparam int MUL_W = 2 * SAMPLE_BITS;

   logic signed [PROD_W-1:0] hist_mem [WINDOW_MAX];

   logic signed [MUL_W-1:0]   prod;
   logic signed [MUL_W:0]     biased;
   logic signed [PROD_W-1:0]  np_in;
   logic signed [PROD_W-1:0]  np_ff;
   logic signed [PROD_W-1:0]  rd_ff;
   logic signed [SUM_W-1:0]   sum_in;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [2*SUM_W-1:0] sq_full;
   logic [SQ_W-1:0]           square_ff;

   // mix with the tone, q15 product rounded half up
   assign prod   = sample * coef;
   assign biased = (MUL_W+1)'(prod) + (MUL_W+1)'(1 << (ROM_FRAC - 1));
   assign np_in  = biased[ROM_FRAC+PROD_W-1:ROM_FRAC];

   // product and the leaving history entry
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         np_ff <= np_in;
         rd_ff <= hist_mem[rd_addr];
      end
   end

   // history write-back
   always_ff @(posedge clock) begin
      if (ctl.load_sum) begin
         hist_mem[wr_addr] <= np_ff;
      end
   end

   // running window sum
   assign sum_in = sum_ff + SUM_W'(np_ff) - (ctl.warm ? SUM_W'(0) : SUM_W'(rd_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (ctl.load_sum) begin
         sum_ff <= sum_in;
      end
   end

   // square of the sum
   assign sq_full = sum_ff * sum_ff;

   always_ff @(posedge clock) begin
      if (ctl.load_sq) begin
         square_ff <= sq_full[SQ_W-1:0];
      end
   end

   assign square = square_ff;

endmodule

FILE: design/tad_detect.sv
// ----------------------------------------------------------------------------
// tad_detect: power merge and arrival detector
// Adds the lane squares into channel powers, runs the four-phase arrival
// detector and holds the result register.
// ----------------------------------------------------------------------------
module tad_detect import tad_pkg::*; #(
   parameter int SQ_W = 53
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               load_pow,
   input  logic               warm_in,
   input  logic               load_out,
   input  logic [SQ_W-1:0]    squares [NUM_LANES],
   input  logic [POWER_W-1:0] detect_level,
   input  logic [POWER_W-1:0] release_level,
   output result_type         result
);

   localparam int PSUM_W = (SQ_W + 1 > POWER_W) ? SQ_W + 1 : POWER_W + 1;

   logic [PSUM_W-1:0]  left_sum;
   logic [PSUM_W-1:0]  right_sum;
   logic [POWER_W-1:0] lp_in;
   logic [POWER_W-1:0] rp_in;
   logic [POWER_W-1:0] lp_ff;
   logic [POWER_W-1:0] rp_ff;
   logic               warm_ff;

   logic [1:0]         mode_ff;
   logic [1:0]         mode_in;
   logic [LAG_W-1:0]   lag_ff [2];
   logic [LAG_W-1:0]   lag_in [2];
   logic [POWER_W-1:0] peak_ff [2];
   logic [POWER_W-1:0] peak_in [2];
   result_type         result_ff;
   result_type         result_in;

   function automatic logic [POWER_W-1:0] peak_max(input logic [POWER_W-1:0] a,
                                                   input logic [POWER_W-1:0] b);
      return (b > a) ? b : a;
   endfunction

   function automatic logic [LAG_W-1:0] lag_sat(input logic [LAG_W-1:0] a);
      return (a == LAG_MAX) ? a : a + 1'b1;
   endfunction

   // channel powers, saturated
   assign left_sum  = PSUM_W'(squares[LANE_LEFT_SIN]) + PSUM_W'(squares[LANE_LEFT_COS]);
   assign right_sum = PSUM_W'(squares[LANE_RIGHT_SIN]) + PSUM_W'(squares[LANE_RIGHT_COS]);
   assign lp_in = (left_sum > PSUM_W'(POWER_MAX)) ? POWER_MAX : left_sum[POWER_W-1:0];
   assign rp_in = (right_sum > PSUM_W'(POWER_MAX)) ? POWER_MAX : right_sum[POWER_W-1:0];

   always_ff @(posedge clock) begin
      if (load_pow) begin
         lp_ff   <= lp_in;
         rp_ff   <= rp_in;
         warm_ff <= warm_in;
      end
   end

   // detector next state and result
   always_comb begin
      logic               la;
      logic               ra;
      logic               done;
      logic [POWER_W-1:0] pk_l;
      logic [POWER_W-1:0] pk_r;
      la         = lp_ff > detect_level;
      ra         = rp_ff > detect_level;
      done       = 1'b0;
      mode_in    = mode_ff;
      lag_in     = lag_ff;
      peak_in    = peak_ff;
      pk_l       = peak_max(peak_ff[0], lp_ff);
      pk_r       = peak_max(peak_ff[1], rp_ff);
      if (!warm_ff) begin
         unique case (mode_ff)
            MODE_IDLE: begin
               if (la && ra) begin
                  peak_in[0] = pk_l;
                  peak_in[1] = pk_r;
                  mode_in    = MODE_WAIT_RELEASE;
               end else if (la) begin
                  peak_in[0] = pk_l;
                  lag_in[1]  = lag_sat(lag_ff[1]);
                  mode_in    = MODE_WAIT_RIGHT;
               end else if (ra) begin
                  peak_in[1] = pk_r;
                  lag_in[0]  = lag_sat(lag_ff[0]);
                  mode_in    = MODE_WAIT_LEFT;
               end
            end
            MODE_WAIT_LEFT: begin
               if (la) begin
                  peak_in[0] = pk_l;
                  mode_in    = MODE_WAIT_RELEASE;
               end else begin
                  lag_in[0] = lag_sat(lag_ff[0]);
               end
               peak_in[1] = pk_r;
            end
            MODE_WAIT_RIGHT: begin
               if (ra) begin
                  peak_in[1] = pk_r;
                  mode_in    = MODE_WAIT_RELEASE;
               end else begin
                  lag_in[1] = lag_sat(lag_ff[1]);
               end
               peak_in[0] = pk_l;
            end
            MODE_WAIT_RELEASE: begin
               peak_in[0] = pk_l;
               peak_in[1] = pk_r;
               if (lp_ff < release_level && rp_ff < release_level) begin
                  done       = 1'b1;
                  lag_in[0]  = '0;
                  lag_in[1]  = '0;
                  peak_in[0] = '0;
                  peak_in[1] = '0;
                  mode_in    = MODE_IDLE;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end
      result_in.left_power     = warm_ff ? '0 : lp_ff;
      result_in.right_power    = warm_ff ? '0 : rp_ff;
      result_in.ping_done      = done;
      result_in.left_lag       = done ? lag_ff[0] : '0;
      result_in.right_lag      = done ? lag_ff[1] : '0;
      result_in.left_peak_out  = done ? pk_l : '0;
      result_in.right_peak_out = done ? pk_r : '0;
      result_in.detector_phase = mode_in;
   end

   // detector state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         lag_ff[0]  <= '0;
         lag_ff[1]  <= '0;
         peak_ff[0] <= '0;
         peak_ff[1] <= '0;
      end else if (load_out) begin
         mode_ff <= mode_in;
         lag_ff  <= lag_in;
         peak_ff <= peak_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (load_out) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

FILE: design/two_channel_tone_arrival_delay.sv
// A result moves through the product, sum, square, power and result registers,
// held on output stall. No pair is taken while one is in the product register.
// History reads the leaving entry at transfer and writes the new at sum load.
// Reset: synchronous; counters, sums and the detector clear, registers take
// their defaults, and the history memories need no clearing pass.
// ----------------------------------------------------------------------------
// two_channel_tone_arrival_delay: stereo tone arrival delay detector
// Four sliding single-bin correlator lanes feed a power merge and a
// four-phase detector that times the lag between the two channels.
// ----------------------------------------------------------------------------
module two_channel_tone_arrival_delay import tad_pkg::*; #(
   parameter int TONE_PERIOD = TONE_PERIOD_DEF,
   parameter int WINDOW_MAX  = WINDOW_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   tad_req_if.sink    req_chan,
   tad_rsp_if.source  rsp_chan,
   tad_csr_if.sink    csr_chan
);

   localparam int PH_W  = (TONE_PERIOD > 1) ? $clog2(TONE_PERIOD) : 1;
   localparam int AW    = $clog2(WINDOW_MAX);
   localparam int CW    = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W = PROD_W + AW;
   localparam int SQ_W  = 2 * SUM_W - 1;

   // configuration registers
   logic [WINDOW_W-1:0]        window_ff;
   logic [POWER_W-1:0]         detect_ff;
   logic [POWER_W-1:0]         release_ff;
   logic signed [OFFSET_W-1:0] left_off_ff;
   logic signed [OFFSET_W-1:0] right_off_ff;
   logic                       csr_write;

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_RESET;
         detect_ff    <= DETECT_RESET;
         release_ff   <= RELEASE_RESET;
         left_off_ff  <= '0;
         right_off_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_chan.index)
            CSR_WINDOW_LENGTH: window_ff    <= csr_chan.data[WINDOW_W-1:0];
            CSR_DETECT_LEVEL:  detect_ff    <= csr_chan.data[POWER_W-1:0];
            CSR_RELEASE_LEVEL: release_ff   <= csr_chan.data[POWER_W-1:0];
            CSR_LEFT_OFFSET:   left_off_ff  <= csr_chan.data[OFFSET_W-1:0];
            CSR_RIGHT_OFFSET:  right_off_ff <= csr_chan.data[OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   // tone table
   logic signed [SAMPLE_BITS-1:0] sin_tab [TONE_PERIOD];
   logic signed [SAMPLE_BITS-1:0] cos_tab [TONE_PERIOD];

   for (genvar i = 0; i < TONE_PERIOD; i++) begin : g_rom
      localparam logic [31:0] ANGLE = 32'((64'(i) << 32) / TONE_PERIOD);
      assign sin_tab[i] = tad_rom_value(ANGLE);
      assign cos_tab[i] = tad_rom_value(ANGLE + 32'h4000_0000);
   end

   // pipeline occupancy
   logic a_v_ff, b_v_ff, c_v_ff, d_v_ff, out_v_ff;
   logic warm_a_ff, warm_b_ff, warm_c_ff;
   logic flow;
   logic accept;

   assign flow           = !out_v_ff || rsp_chan.ready;
   assign req_chan.ready = flow && !a_v_ff;
   assign accept         = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff   <= 1'b0;
         b_v_ff   <= 1'b0;
         c_v_ff   <= 1'b0;
         d_v_ff   <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (flow) begin
         a_v_ff   <= accept;
         b_v_ff   <= a_v_ff;
         c_v_ff   <= b_v_ff;
         d_v_ff   <= c_v_ff;
         out_v_ff <= d_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (flow) begin
         warm_b_ff <= warm_a_ff;
         warm_c_ff <= warm_b_ff;
      end
   end

   // window bookkeeping
   logic [PH_W-1:0] phase_ff;
   logic [CW-1:0]   fill_ff;
   logic [AW-1:0]   wr_ff;
   logic [AW-1:0]   wr_a_ff;
   logic [CW-1:0]   win_c;
   logic            warm_now;
   logic [CW:0]     wr_ext;
   logic [CW:0]     old_ext;
   logic [AW-1:0]   rd_addr;

   always_comb begin
      if (window_ff == '0) begin
         win_c = CW'(1);
      end else if (32'(window_ff) > 32'(WINDOW_MAX)) begin
         win_c = CW'(WINDOW_MAX);
      end else begin
         win_c = CW'(window_ff);
      end
   end

   assign warm_now = fill_ff < win_c;
   assign wr_ext   = (CW+1)'(wr_ff);

   // oldest entry still inside the window
   always_comb begin
      if (wr_ext >= (CW+1)'(fill_ff)) begin
         old_ext = wr_ext - (CW+1)'(fill_ff);
      end else begin
         old_ext = wr_ext + (CW+1)'(WINDOW_MAX) - (CW+1)'(fill_ff);
      end
   end

   assign rd_addr = old_ext[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         fill_ff  <= '0;
         wr_ff    <= '0;
      end else if (accept) begin
         phase_ff <= (phase_ff == PH_W'(TONE_PERIOD - 1)) ? '0 : phase_ff + 1'b1;
         if (warm_now) begin
            fill_ff <= fill_ff + 1'b1;
         end
         wr_ff <= (wr_ff == AW'(WINDOW_MAX - 1)) ? '0 : wr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         wr_a_ff   <= wr_ff;
         warm_a_ff <= warm_now;
      end
   end

   // offset removal
   logic signed [SAMPLE_BITS-1:0] left_prep;
   logic signed [SAMPLE_BITS-1:0] right_prep;

   assign left_prep  = tad_prep(req_chan.left_sample, left_off_ff);
   assign right_prep = tad_prep(req_chan.right_sample, right_off_ff);

   // correlator lanes
   lane_ctl_type                  lane_ctl;
   logic signed [SAMPLE_BITS-1:0] lane_sample [NUM_LANES];
   logic signed [SAMPLE_BITS-1:0] lane_coef   [NUM_LANES];
   logic [SQ_W-1:0]               squares     [NUM_LANES];

   assign lane_ctl.accept   = accept;
   assign lane_ctl.load_sum = a_v_ff && flow;
   assign lane_ctl.load_sq  = b_v_ff && flow;
   assign lane_ctl.warm     = warm_a_ff;

   assign lane_sample[LANE_LEFT_SIN]  = left_prep;
   assign lane_sample[LANE_LEFT_COS]  = left_prep;
   assign lane_sample[LANE_RIGHT_SIN] = right_prep;
   assign lane_sample[LANE_RIGHT_COS] = right_prep;
   assign lane_coef[LANE_LEFT_SIN]    = sin_tab[phase_ff];
   assign lane_coef[LANE_LEFT_COS]    = cos_tab[phase_ff];
   assign lane_coef[LANE_RIGHT_SIN]   = sin_tab[phase_ff];
   assign lane_coef[LANE_RIGHT_COS]   = cos_tab[phase_ff];

   for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      tad_lane #(
         .WINDOW_MAX (WINDOW_MAX)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctl     (lane_ctl),
         .sample  (lane_sample[k]),
         .coef    (lane_coef[k]),
         .rd_addr (rd_addr),
         .wr_addr (wr_a_ff),
         .square  (squares[k])
      );
   end

   // merge and detect
   result_type result;

   tad_detect #(
      .SQ_W (SQ_W)
   ) u_detect (
      .clock         (clock),
      .reset         (reset),
      .load_pow      (c_v_ff && flow),
      .warm_in       (warm_c_ff),
      .load_out      (d_v_ff && flow),
      .squares       (squares),
      .detect_level  (detect_ff),
      .release_level (release_ff),
      .result        (result)
   );

   // result transfer
   assign rsp_chan.valid          = out_v_ff;
   assign rsp_chan.left_power     = result.left_power;
   assign rsp_chan.right_power    = result.right_power;
   assign rsp_chan.ping_done      = result.ping_done;
   assign rsp_chan.left_lag       = result.left_lag;
   assign rsp_chan.right_lag      = result.right_lag;
   assign rsp_chan.left_peak_out  = result.left_peak_out;
   assign rsp_chan.right_peak_out = result.right_peak_out;
   assign rsp_chan.detector_phase = result.detector_phase;

endmodule
